// ----- design/sm3e_pkg.sv -----
// Shared types, constants and bit functions for the SM3 hash engine.
`default_nettype none
package sm3e_pkg;

  localparam logic [31:0] T_LOW  = 32'h79CC4519;
  localparam logic [31:0] T_HIGH = 32'h7A879D8A;
  localparam logic [7:0]  PAD_MARK = 8'h80;
  localparam logic [5:0]  LEN_POS  = 6'd56;
  localparam logic [5:0]  LAST_ROUND = 6'd63;
  localparam logic [2:0]  LAST_WORD_IDX = 3'd7;

  localparam logic [7:0][31:0] IV = {
    32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
    32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_OUT
  } state_t;

  // Controls from the sequencer to the compression unit.
  typedef struct packed {
    logic start;  // load working variables, begin 64 rounds
    logic push;   // shift a new message word into the schedule window
  } comp_ctl_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
    rotl32 = (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    perm0 = x ^ rotl32(x, 9) ^ rotl32(x, 17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    perm1 = x ^ rotl32(x, 15) ^ rotl32(x, 23);
  endfunction

endpackage
`default_nettype wire

// ----- design/sm3e_compress.sv -----
// SM3 compression unit: one round per cycle with a 16-word schedule window.
`default_nettype none
module sm3e_compress (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire sm3e_pkg::comp_ctl_t   ctl,
  input  wire logic [31:0]           push_word,
  input  wire logic [7:0][31:0]      cv,
  output logic                       done,
  output logic [7:0][31:0]           result
);

  logic [15:0][31:0] win;
  logic [7:0][31:0]  v;
  logic [5:0]        round;
  logic [31:0]       t_rot;
  logic              active;

  logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, w_new;
  logic        early;

  assign early = (round[5:4] == 2'b00);

  always_comb begin
    a12 = sm3e_pkg::rotl32(v[0], 12);
    ss1 = sm3e_pkg::rotl32(a12 + v[4] + t_rot, 7);
    ss2 = ss1 ^ a12;
    if (early) begin
      ff = v[0] ^ v[1] ^ v[2];
      gg = v[4] ^ v[5] ^ v[6];
    end else begin
      ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
      gg = (v[4] & v[5]) | (~v[4] & v[6]);
    end
    tt1 = ff + v[3] + ss2 + (win[0] ^ win[4]);
    tt2 = gg + v[7] + ss1 + win[0];
    w_new = sm3e_pkg::perm1(win[0] ^ win[7] ^ sm3e_pkg::rotl32(win[13], 15))
          ^ sm3e_pkg::rotl32(win[3], 7) ^ win[10];
    result[0] = tt1;
    result[1] = v[0];
    result[2] = sm3e_pkg::rotl32(v[1], 9);
    result[3] = v[2];
    result[4] = sm3e_pkg::perm0(tt2);
    result[5] = v[4];
    result[6] = sm3e_pkg::rotl32(v[5], 19);
    result[7] = v[6];
  end

  assign done = active && (round == sm3e_pkg::LAST_ROUND);

  // Schedule window: win[0] is the word of the current round.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      win <= {push_word, win[15:1]};
    end else if (active) begin
      win <= {w_new, win[15:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      v     <= cv;
      t_rot <= sm3e_pkg::T_LOW;
    end else if (active) begin
      v <= result;
      if (round == 6'd15) begin
        t_rot <= sm3e_pkg::rotl32(sm3e_pkg::T_HIGH, 16);
      end else begin
        t_rot <= sm3e_pkg::rotl32(t_rot, 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      round  <= '0;
    end else if (ctl.start) begin
      active <= 1'b1;
      round  <= '0;
    end else if (active) begin
      round <= round + 6'd1;
      if (done) begin
        active <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/sm3_hash_engine_top.sv -----
// Top level of the streaming SM3 hash engine.
//
// Usage:
//   Input stream (s_*): one message byte per request. s_tdata carries the
//   byte, s_tuser marks it as a real byte, s_tlast ends the message. A
//   request with s_tuser low adds nothing; with s_tlast high it still
//   finishes the message, so an empty message is one such request.
//   Output stream (m_*): eight requests per message, the 256-bit digest as
//   big-endian 32-bit words, word 0 first; m_tlast marks word 7.
//   Throughput: one byte per cycle while the 64-byte block fills; each full
//   block then holds s_tready low while the shared round unit compresses
//   it, one SM3 round per cycle. After the last byte, padding bytes go in
//   one per cycle up to the block end, then each padding block (one or
//   two) is compressed, then the eight digest words leave, one per cycle
//   while m_tready is high.
//   A stalled receiver holds the current word; no new input is taken until
//   word 7 is delivered, after which the chaining value returns to the IV.
//   Reset (rst, synchronous, active high) loads the IV and clears the fill
//   count, bit length and sequencer.
`default_nettype none
module sm3_hash_engine_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] msg_byte
  input  wire logic        s_tuser,   // [0] byte_valid
  input  wire logic        s_tlast,   // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
  output logic             m_tlast    // last_word
);

  sm3e_pkg::state_t    state, state_next;
  sm3e_pkg::comp_ctl_t ctl;

  logic [7:0][31:0] cv;
  logic [7:0][31:0] result;
  logic             done;
  logic [23:0]      acc;
  logic [5:0]       fill;
  logic [63:0]      bit_length;
  logic             padding;
  logic             pad_first;
  logic             len_ok;
  logic             final_blk;
  logic [2:0]       out_idx;

  logic        s_fire, m_fire;
  logic        push_en, wrap;
  logic [7:0]  push_byte, pad_byte;
  logic [5:0]  len_base;

  assign s_fire = s_tvalid && s_tready;
  assign m_fire = m_tvalid && m_tready;

  // Padding byte: marker, then zeros, then the big-endian bit length in
  // the last eight positions of the final block.
  assign len_base = {~fill[2:0], 3'b000};
  always_comb begin
    if (pad_first) begin
      pad_byte = sm3e_pkg::PAD_MARK;
    end else if (len_ok && (fill >= sm3e_pkg::LEN_POS)) begin
      pad_byte = bit_length[len_base +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    push_en   = 1'b0;
    push_byte = s_tdata;
    case (state)
      sm3e_pkg::ST_IDLE: begin
        push_en = s_fire && s_tuser;
      end
      sm3e_pkg::ST_PAD: begin
        push_en   = 1'b1;
        push_byte = pad_byte;
      end
      default: begin
        push_en = 1'b0;
      end
    endcase
  end

  assign wrap      = push_en && (fill == 6'd63);
  assign ctl.push  = push_en && (fill[1:0] == 2'b11);
  assign ctl.start = wrap;

  sm3e_compress u_compress (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .push_word ({acc, push_byte}),
    .cv        (cv),
    .done      (done),
    .result    (result)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      sm3e_pkg::ST_IDLE: begin
        if (s_fire) begin
          if (wrap) begin
            state_next = sm3e_pkg::ST_COMP;
          end else if (s_tlast) begin
            state_next = sm3e_pkg::ST_PAD;
          end
        end
      end
      sm3e_pkg::ST_PAD: begin
        if (wrap) begin
          state_next = sm3e_pkg::ST_COMP;
        end
      end
      sm3e_pkg::ST_COMP: begin
        if (done) begin
          if (final_blk) begin
            state_next = sm3e_pkg::ST_OUT;
          end else if (padding) begin
            state_next = sm3e_pkg::ST_PAD;
          end else begin
            state_next = sm3e_pkg::ST_IDLE;
          end
        end
      end
      sm3e_pkg::ST_OUT: begin
        if (m_fire && (out_idx == sm3e_pkg::LAST_WORD_IDX)) begin
          state_next = sm3e_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sm3e_pkg::ST_IDLE;
      end
    endcase
  end

  // Port outputs.
  always_comb begin
    s_tready = (state == sm3e_pkg::ST_IDLE);
    m_tvalid = (state == sm3e_pkg::ST_OUT);
    m_tdata  = {5'b00000, out_idx, cv[out_idx]};
    m_tlast  = (out_idx == sm3e_pkg::LAST_WORD_IDX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sm3e_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Byte collector: gather three bytes, the fourth completes a word.
  always_ff @(posedge clk) begin
    if (push_en) begin
      acc <= {acc[15:0], push_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv         <= sm3e_pkg::IV;
      fill       <= '0;
      bit_length <= '0;
      padding    <= 1'b0;
      pad_first  <= 1'b0;
      len_ok     <= 1'b0;
      final_blk  <= 1'b0;
      out_idx    <= '0;
    end else begin
      if (push_en) begin
        fill <= fill + 6'd1;
      end
      if ((state == sm3e_pkg::ST_IDLE) && s_fire) begin
        if (s_tuser) begin
          bit_length <= bit_length + 64'd8;
        end
        if (s_tlast) begin
          padding   <= 1'b1;
          pad_first <= 1'b1;
          len_ok    <= 1'b0;
        end
      end
      if (state == sm3e_pkg::ST_PAD) begin
        pad_first <= 1'b0;
        // Marker below the length field: length fits in this block.
        if (pad_first && (fill < sm3e_pkg::LEN_POS)) begin
          len_ok <= 1'b1;
        end
        if (wrap) begin
          len_ok <= 1'b1;
          if (len_ok && !pad_first) begin
            final_blk <= 1'b1;
          end
        end
      end
      if (done) begin
        for (int k = 0; k < 8; k++) begin
          cv[k] <= cv[k] ^ result[k];
        end
      end
      if (m_fire) begin
        out_idx <= out_idx + 3'd1;
        // Last word gone: back to the IV for the next message.
        if (out_idx == sm3e_pkg::LAST_WORD_IDX) begin
          cv         <= sm3e_pkg::IV;
          bit_length <= '0;
          padding    <= 1'b0;
          final_blk  <= 1'b0;
          len_ok     <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire
